[hdl/mcvs_pkg.sv]
package mcvs_pkg;

    // payload widths
    localparam int COST_W = 16;
    localparam int ACC_W  = 23;
    localparam int IDX_W  = 6;

    // configuration port
    localparam int CFG_W    = 7;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;
    localparam logic [CFG_W-1:0] CFG_DIM_RESET = 7'd64;

    // register index, taken from paddr bit 2
    localparam logic REG_COLS = 1'b0;
    localparam logic REG_ROWS = 1'b1;

    // step choice kept per cell
    typedef enum logic [1:0] {
        STEP_DOWN  = 2'd0,
        STEP_LEFT  = 2'd1,
        STEP_RIGHT = 2'd2
    } t_step;

    // commands from controller to datapath
    typedef struct packed {
        logic             load;
        logic             calc;
        logic             scan_rd;
        logic             scan_cmp;
        logic             scan_first;
        logic             emit;
        logic             step;
        logic             first_row;
        logic             has_left;
        logic             has_right;
        logic             last;
        logic [IDX_W-1:0] col;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] cols_m1;
    } t_ctl_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic out_free;
    } t_dp_status;

endpackage

[hdl/mcvs_ifs.sv]
interface mcvs_cost_if;
    import mcvs_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [COST_W-1:0] cost;
    modport source (output valid, output cost, input ready);
    modport sink (input valid, input cost, output ready);
endinterface

interface mcvs_seam_if;
    import mcvs_pkg::*;
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] column;
    logic             last;
    modport source (output valid, output row, output column, output last, input ready);
    modport sink (input valid, input row, input column, input last, output ready);
endinterface

[hdl/mcvs_ctrl.sv]
module mcvs_ctrl #(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_cfg_wr,
    input  logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] i_cols_m1,
    input  logic [((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1)-1:0] i_rows_m1,
    input  mcvs_pkg::t_dp_status  i_status,
    output mcvs_pkg::t_ctl_cmd    o_cmd
);
    import mcvs_pkg::*;

    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CALC,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_EMIT,
        S_STEP
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic [CW-1:0] r_scan, n_scan;
    logic [RW-1:0] r_walk, n_walk;
    logic          w_accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_col   = r_col;
        n_row   = r_row;
        n_scan  = r_scan;
        n_walk  = r_walk;
        o_cmd   = '0;
        o_cmd.cols_m1   = IDX_W'(i_cols_m1);
        o_cmd.col       = IDX_W'(r_col);
        o_cmd.row       = IDX_W'(r_row);
        o_cmd.first_row = (r_row == '0);
        o_cmd.has_left  = (r_col != '0);
        o_cmd.has_right = (r_col != i_cols_m1);
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CALC;
                end
            end
            S_CALC: begin
                o_cmd.calc = 1'b1;
                if (r_col == i_cols_m1) begin
                    n_col = '0;
                    if (r_row == i_rows_m1) begin
                        n_row   = '0;
                        n_scan  = '0;
                        n_state = S_SCAN_RD;
                    end else begin
                        n_row   = r_row + RW'(1);
                        n_state = S_IDLE;
                    end
                end else begin
                    n_col   = r_col + CW'(1);
                    n_state = S_IDLE;
                end
            end
            S_SCAN_RD: begin
                o_cmd.scan_rd = 1'b1;
                o_cmd.col     = IDX_W'(r_scan);
                n_state       = S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                o_cmd.scan_cmp   = 1'b1;
                o_cmd.col        = IDX_W'(r_scan);
                o_cmd.scan_first = (r_scan == '0);
                if (r_scan == i_cols_m1) begin
                    n_walk  = i_rows_m1;
                    n_state = S_EMIT;
                end else begin
                    n_scan  = r_scan + CW'(1);
                    n_state = S_SCAN_RD;
                end
            end
            S_EMIT: begin
                o_cmd.row  = IDX_W'(r_walk);
                o_cmd.last = (r_walk == '0);
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = (r_walk == '0) ? S_IDLE : S_STEP;
                end
            end
            S_STEP: begin
                o_cmd.step = 1'b1;
                n_walk     = r_walk - RW'(1);
                n_state    = S_EMIT;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        // a register write restarts the map
        if (i_cfg_wr) begin
            n_col = '0;
            n_row = '0;
        end
    end

    // state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_col   <= '0;
            r_row   <= '0;
            r_scan  <= '0;
            r_walk  <= '0;
        end else begin
            r_state <= n_state;
            r_col   <= n_col;
            r_row   <= n_row;
            r_scan  <= n_scan;
            r_walk  <= n_walk;
        end
    end

`ifndef ASSERT_OFF
    a_pos_in_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col <= i_cols_m1) && (r_row <= i_rows_m1))
        else $error("cell position outside the map");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN_RD || r_state == S_SCAN_CMP) |-> (r_scan <= i_cols_m1))
        else $error("column scan past the last column");

    a_accept_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_CALC))
        else $error("accepted word not followed by update");

    a_walk_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit && o_cmd.last) |=> (r_state == S_IDLE))
        else $error("walk did not finish after row 0");
`endif

endmodule

[hdl/mcvs_dp.sv]
module mcvs_dp #(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic signed [mcvs_pkg::COST_W-1:0] i_cost,
    input  mcvs_pkg::t_ctl_cmd                i_cmd,
    output mcvs_pkg::t_dp_status              o_status,
    mcvs_seam_if.source                       o_seam
);
    import mcvs_pkg::*;

    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    // cumulative cost line, updated in place
    logic signed [ACC_W-1:0] r_line [MAX_COLS];
    // step choice per cell
    t_step                   r_choice [MAX_ROWS][MAX_COLS];

    logic signed [ACC_W-1:0] r_cost;
    logic signed [ACC_W-1:0] r_rd_a;
    logic signed [ACC_W-1:0] r_rd_b;
    logic signed [ACC_W-1:0] r_left;
    logic signed [ACC_W-1:0] r_min;
    logic [CW-1:0]           r_cur;
    t_step                   r_ch;
    logic                    r_out_valid;
    logic [IDX_W-1:0]        r_out_row;
    logic [IDX_W-1:0]        r_out_col;
    logic                    r_out_last;

    logic [CW-1:0]           w_col;
    logic [CW-1:0]           w_col_nb;
    logic [RW-1:0]           w_row;
    logic [CW-1:0]           w_cols_m1;
    logic signed [ACC_W-1:0] n_best;
    t_step                   n_choice;
    logic signed [ACC_W-1:0] n_sum;

    assign w_col     = i_cmd.col[CW-1:0];
    assign w_row     = i_cmd.row[RW-1:0];
    assign w_cols_m1 = i_cmd.cols_m1[CW-1:0];
    assign w_col_nb  = (w_col == CW'(MAX_COLS - 1)) ? '0 : w_col + CW'(1);

    // pick the cheapest neighbor above, straight down on ties
    always_comb begin
        n_best   = r_rd_a;
        n_choice = STEP_DOWN;
        if (i_cmd.has_left && (r_left < n_best)) begin
            n_best   = r_left;
            n_choice = STEP_LEFT;
        end
        if (i_cmd.has_right && (r_rd_b < n_best)) begin
            n_best   = r_rd_b;
            n_choice = STEP_RIGHT;
        end
        n_sum = i_cmd.first_row ? r_cost : r_cost + n_best;
    end

    // cost line: two reads per word, one write
    always_ff @(posedge i_clk) begin
        if (i_cmd.load || i_cmd.scan_rd) begin
            r_rd_a <= r_line[w_col];
        end
        if (i_cmd.load) begin
            r_rd_b <= r_line[w_col_nb];
        end
        if (i_cmd.calc) begin
            r_line[w_col] <= n_sum;
        end
    end

    // choice memory: write on update, read on emit
    always_ff @(posedge i_clk) begin
        if (i_cmd.calc && !i_cmd.first_row) begin
            r_choice[w_row][w_col] <= n_choice;
        end
        if (i_cmd.emit) begin
            r_ch <= r_choice[w_row][r_cur];
        end
    end

    // word latch, left tap, minimum search and seam column
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cost <= {{(ACC_W - COST_W){i_cost[COST_W-1]}}, i_cost};
        end
        if (i_cmd.calc) begin
            r_left <= r_rd_a;
        end
        if (i_cmd.scan_cmp && (i_cmd.scan_first || (r_rd_a < r_min))) begin
            r_min <= r_rd_a;
            r_cur <= w_col;
        end
        if (i_cmd.step) begin
            case (r_ch)
                STEP_LEFT: begin
                    if (r_cur != '0) r_cur <= r_cur - CW'(1);
                end
                STEP_RIGHT: begin
                    if (r_cur != w_cols_m1) r_cur <= r_cur + CW'(1);
                end
                default: begin
                    r_cur <= r_cur;
                end
            endcase
        end
        if (i_cmd.emit) begin
            r_out_row  <= i_cmd.row;
            r_out_col  <= IDX_W'(r_cur);
            r_out_last <= i_cmd.last;
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (o_seam.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.out_free = !r_out_valid || o_seam.ready;
    assign o_seam.valid  = r_out_valid;
    assign o_seam.row    = r_out_row;
    assign o_seam.column = r_out_col;
    assign o_seam.last   = r_out_last;

`ifndef ASSERT_OFF
    a_last_row0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_last) |-> (r_out_row == '0))
        else $error("last word not on row 0");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> (r_out_valid && (r_out_last == $past(i_cmd.last))))
        else $error("emitted word lost");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_seam.ready) |=> (r_out_valid && $stable(r_out_row)
            && $stable(r_out_col) && $stable(r_out_last)))
        else $error("stalled word changed");
`endif

endmodule

[hdl/min_cost_vertical_seam_core.sv]
// channel    | dir | payload                    | handshake
// -----------+-----+----------------------------+--------------------------
// i_cost_ch  | in  | cost s16, row-major        | valid/ready
// o_seam_ch  | out | row u6, column u6, last    | valid/ready
// apb        | in  | cols_in_use @0, rows @4    | psel/penable, pready = 1
//
// each cost word: fetch of the line row above, then update; after the last
// word: read and compare per column for the minimum search over the line
// memory, then emit and step per row for the walk back, only emit for row 0
// synchronous active-low reset clears control; cost and choice memories
// are not cleared, the walk only reads cells of the current map
// a stalled output holds the walk; input is refused from the last word
// until the row 0 word has been loaded into the output register
module min_cost_vertical_seam_core #(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    mcvs_cost_if.sink                     i_cost_ch,
    mcvs_seam_if.source                   o_seam_ch,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mcvs_pkg::APB_AW-1:0]   paddr,
    input  logic [mcvs_pkg::APB_DW-1:0]   pwdata,
    output logic [mcvs_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    import mcvs_pkg::*;

    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    logic [CFG_W-1:0] r_cfg_cols;
    logic [CFG_W-1:0] r_cfg_rows;
    logic             w_cfg_wr;
    logic [CW-1:0]    w_cols_m1;
    logic [RW-1:0]    w_rows_m1;
    t_ctl_cmd         w_cmd;
    t_dp_status       w_status;

    // register writes
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_cols <= CFG_DIM_RESET;
            r_cfg_rows <= CFG_DIM_RESET;
        end else if (w_cfg_wr) begin
            if (paddr[2] == REG_ROWS) begin
                r_cfg_rows <= pwdata[CFG_W-1:0];
            end else begin
                r_cfg_cols <= pwdata[CFG_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_ROWS) ? APB_DW'(r_cfg_rows) : APB_DW'(r_cfg_cols);

    // clamp map size to 1..max, kept as size minus one
    always_comb begin
        if (r_cfg_cols == '0) begin
            w_cols_m1 = '0;
        end else if (r_cfg_cols > CFG_W'(MAX_COLS)) begin
            w_cols_m1 = CW'(MAX_COLS - 1);
        end else begin
            w_cols_m1 = CW'(r_cfg_cols - CFG_W'(1));
        end
        if (r_cfg_rows == '0) begin
            w_rows_m1 = '0;
        end else if (r_cfg_rows > CFG_W'(MAX_ROWS)) begin
            w_rows_m1 = RW'(MAX_ROWS - 1);
        end else begin
            w_rows_m1 = RW'(r_cfg_rows - CFG_W'(1));
        end
    end

    mcvs_ctrl #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cost_ch.valid),
        .o_in_ready (i_cost_ch.ready),
        .i_cfg_wr   (w_cfg_wr),
        .i_cols_m1  (w_cols_m1),
        .i_rows_m1  (w_rows_m1),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    mcvs_dp #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cost   (i_cost_ch.cost),
        .i_cmd    (w_cmd),
        .o_status (w_status),
        .o_seam   (o_seam_ch)
    );

endmodule
